@@ sv/prrs_pkg.sv @@
// Shared types, constants and helpers for the page rectangle rotate/scale block.
`default_nettype none
package prrs_pkg;

    localparam int CoordW    = 32;
    localparam int SizeW     = 32;
    localparam int ProdW     = 63;
    localparam int DivStages = ProdW;
    localparam int QW        = 42;
    localparam int OffW      = 34;
    localparam int AccW      = 44;
    localparam int AddrW     = 6;
    localparam int DataW     = 64;
    localparam int RotW      = 9;
    localparam int StatusW   = 2;

    localparam logic [ProdW-1:0] QClamp = ProdW'(64'd1099511627776);

    localparam logic [RotW-1:0] ROT_DEG_0   = RotW'(0);
    localparam logic [RotW-1:0] ROT_DEG_90  = RotW'(90);
    localparam logic [RotW-1:0] ROT_DEG_180 = RotW'(180);
    localparam logic [RotW-1:0] ROT_DEG_270 = RotW'(270);

    localparam logic [StatusW-1:0] ST_OK  = 2'd0;
    localparam logic [StatusW-1:0] ST_BOX = 2'd1;
    localparam logic [StatusW-1:0] ST_ROT = 2'd2;

    typedef enum logic [2:0] {
        REG_MEDIA_X = 3'd0,
        REG_MEDIA_Y = 3'd1,
        REG_CROP_X  = 3'd2,
        REG_CROP_Y  = 3'd3,
        REG_ROT     = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        ROT_0,
        ROT_90,
        ROT_180,
        ROT_270
    } rot_t;

    typedef struct packed {
        rot_t                       rot;
        logic [StatusW-1:0]         status;
        logic signed [OffW-1:0]     off_x;
        logic signed [OffW-1:0]     off_y;
        logic [SizeW-1:0]           num_x;
        logic [SizeW-1:0]           den_x;
        logic [SizeW-1:0]           num_y;
        logic [SizeW-1:0]           den_y;
    } page_cfg_t;

    function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [AccW-1:0] v);
        logic signed [AccW-1:0] hi;
        logic signed [AccW-1:0] lo;
        hi = AccW'(64'sd2147483647);
        lo = -AccW'(64'sd2147483648);
        if (v > hi)
            return CoordW'(hi);
        else if (v < lo)
            return CoordW'(lo);
        else
            return v[CoordW-1:0];
    endfunction

endpackage
`default_nettype wire

@@ sv/prrs_cfg.sv @@
// Configuration registers, APB access and derived page geometry.
`default_nettype none
module prrs_cfg (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [prrs_pkg::AddrW-1:0] paddr,
    input  wire logic [prrs_pkg::DataW-1:0] pwdata,
    output logic      [prrs_pkg::DataW-1:0] prdata,
    output logic                            pready,
    output prrs_pkg::page_cfg_t             cfg
);
    import prrs_pkg::*;

    logic [DataW-1:0] media_x_reg, media_y_reg, crop_x_reg, crop_y_reg;
    logic [RotW-1:0]  rot_reg;
    logic             wr_en;
    reg_idx_t         idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            media_x_reg <= '0;
            media_y_reg <= '0;
            crop_x_reg  <= '0;
            crop_y_reg  <= '0;
            rot_reg     <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_MEDIA_X: media_x_reg <= pwdata;
                REG_MEDIA_Y: media_y_reg <= pwdata;
                REG_CROP_X:  crop_x_reg  <= pwdata;
                REG_CROP_Y:  crop_y_reg  <= pwdata;
                REG_ROT:     rot_reg     <= pwdata[RotW-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MEDIA_X: prdata = media_x_reg;
            REG_MEDIA_Y: prdata = media_y_reg;
            REG_CROP_X:  prdata = crop_x_reg;
            REG_CROP_Y:  prdata = crop_y_reg;
            REG_ROT:     prdata = DataW'(rot_reg);
            default:     prdata = '0;
        endcase
    end

    // Stage 1: order each box edge pair.
    logic signed [CoordW-1:0] mx0_reg, mx1_reg, my0_reg, my1_reg;
    logic signed [CoordW-1:0] cx0_reg, cx1_reg, cy0_reg, cy1_reg;
    rot_t                     rot_code_reg;
    logic                     rot_bad_reg;
    rot_t                     rot_code_next;
    logic                     rot_bad_next;

    function automatic logic signed [CoordW-1:0] lo_of(input logic [DataW-1:0] r);
        logic signed [CoordW-1:0] a;
        logic signed [CoordW-1:0] b;
        a = r[31:0];
        b = r[63:32];
        return (a > b) ? b : a;
    endfunction

    function automatic logic signed [CoordW-1:0] hi_of(input logic [DataW-1:0] r);
        logic signed [CoordW-1:0] a;
        logic signed [CoordW-1:0] b;
        a = r[31:0];
        b = r[63:32];
        return (a > b) ? a : b;
    endfunction

    always_comb
    begin
        rot_bad_next  = 1'b0;
        rot_code_next = ROT_0;
        priority if (rot_reg == ROT_DEG_0)   rot_code_next = ROT_0;
        else if (rot_reg == ROT_DEG_90)      rot_code_next = ROT_90;
        else if (rot_reg == ROT_DEG_180)     rot_code_next = ROT_180;
        else if (rot_reg == ROT_DEG_270)     rot_code_next = ROT_270;
        else                                 rot_bad_next  = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        mx0_reg <= lo_of(media_x_reg);
        mx1_reg <= hi_of(media_x_reg);
        my0_reg <= lo_of(media_y_reg);
        my1_reg <= hi_of(media_y_reg);
        cx0_reg <= lo_of(crop_x_reg);
        cx1_reg <= hi_of(crop_x_reg);
        cy0_reg <= lo_of(crop_y_reg);
        cy1_reg <= hi_of(crop_y_reg);
        rot_bad_reg  <= rot_bad_next;
        rot_code_reg <= rot_code_next;
    end

    // Stage 2: sizes, status, offsets and scale factors.
    logic [SizeW-1:0]       mw, mh, cw, ch;
    logic signed [OffW-1:0] cx0_e, cy0_e, cw_e, ch_e;
    page_cfg_t              cfg_next;
    page_cfg_t              cfg_reg;

    always_comb
    begin
        mw = SizeW'(33'(mx1_reg) - 33'(mx0_reg));
        mh = SizeW'(33'(my1_reg) - 33'(my0_reg));
        cw = SizeW'(33'(cx1_reg) - 33'(cx0_reg));
        ch = SizeW'(33'(cy1_reg) - 33'(cy0_reg));
        cx0_e = OffW'(cx0_reg);
        cy0_e = OffW'(cy0_reg);
        cw_e  = OffW'({2'b00, cw});
        ch_e  = OffW'({2'b00, ch});

        cfg_next.rot   = rot_code_reg;
        cfg_next.num_x = cw;
        cfg_next.den_x = mw;
        cfg_next.num_y = ch;
        cfg_next.den_y = mh;
        priority if (mw == '0 || mh == '0 || cw == '0 || ch == '0)
            cfg_next.status = ST_BOX;
        else if (rot_bad_reg)
            cfg_next.status = ST_ROT;
        else
            cfg_next.status = ST_OK;

        unique case (rot_code_reg)
            ROT_0:
            begin
                cfg_next.off_x = -cx0_e;
                cfg_next.off_y = -cy0_e;
                cfg_next.num_x = SizeW'(1);
                cfg_next.den_x = SizeW'(1);
                cfg_next.num_y = SizeW'(1);
                cfg_next.den_y = SizeW'(1);
            end
            ROT_90:
            begin
                cfg_next.off_x = cx0_e;
                cfg_next.off_y = cy0_e + cw_e;
            end
            ROT_180:
            begin
                cfg_next.off_x = cx0_e + cw_e;
                cfg_next.off_y = cy0_e + ch_e;
            end
            ROT_270:
            begin
                cfg_next.off_x = cx0_e + ch_e;
                cfg_next.off_y = cy0_e;
            end
            default:
            begin
                cfg_next.off_x = '0;
                cfg_next.off_y = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

@@ sv/prrs_lane.sv @@
// One scaling lane: signed multiply, pipelined restoring divide, clamp.
`default_nettype none
module prrs_lane (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_vld,
    input  wire logic signed [prrs_pkg::CoordW-1:0]  u,
    input  wire logic        [prrs_pkg::SizeW-1:0]   num,
    input  wire logic        [prrs_pkg::SizeW-1:0]   den,
    output logic                                     out_vld,
    output logic signed      [prrs_pkg::QW-1:0]      q
);
    import prrs_pkg::*;

    // Align with the registered settle of the derived configuration.
    logic                     a_vld_reg;
    logic signed [CoordW-1:0] a_u_reg;

    logic [ProdW-1:0] dq_reg  [0:DivStages];
    logic [SizeW-1:0] rem_reg [0:DivStages];
    logic             sgn_reg [0:DivStages];
    logic             vld_reg [0:DivStages];

    logic [SizeW-1:0] mag;
    logic [ProdW-1:0] prod;

    assign mag  = a_u_reg[CoordW-1] ? SizeW'(-a_u_reg) : SizeW'(a_u_reg);
    assign prod = ProdW'(mag) * ProdW'(num);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg  <= 1'b0;
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            a_vld_reg  <= in_vld;
            vld_reg[0] <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_u_reg    <= u;
        dq_reg[0]  <= prod;
        rem_reg[0] <= '0;
        sgn_reg[0] <= a_u_reg[CoordW-1];
    end

    for (genvar k = 0; k < DivStages; k++)
    begin : g_div
        logic [SizeW:0] trial;
        logic           ge;

        assign trial = {rem_reg[k], dq_reg[k][ProdW-1]};
        assign ge    = trial >= {1'b0, den};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else
                vld_reg[k+1] <= vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1] <= ge ? SizeW'(trial - {1'b0, den}) : trial[SizeW-1:0];
            dq_reg[k+1]  <= {dq_reg[k][ProdW-2:0], ge};
            sgn_reg[k+1] <= sgn_reg[k];
        end
    end

    logic              q_vld_reg;
    logic signed [QW-1:0] q_reg;
    logic [ProdW-1:0]  qmag;

    assign qmag = (dq_reg[DivStages] > QClamp) ? QClamp : dq_reg[DivStages];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_vld_reg <= 1'b0;
        else
            q_vld_reg <= vld_reg[DivStages];
    end

    always_ff @(posedge clk)
    begin
        q_reg <= sgn_reg[DivStages] ? -QW'(qmag) : QW'(qmag);
    end

    assign out_vld = q_vld_reg;
    assign q       = q_reg;

endmodule
`default_nettype wire

@@ sv/prrs_post.sv @@
// Output stages: rotate/offset combine, then order and saturate.
`default_nettype none
module prrs_post (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_vld,
    input  wire logic signed [prrs_pkg::QW-1:0]      qx0,
    input  wire logic signed [prrs_pkg::QW-1:0]      qy0,
    input  wire logic signed [prrs_pkg::QW-1:0]      qx1,
    input  wire logic signed [prrs_pkg::QW-1:0]      qy1,
    input  wire prrs_pkg::page_cfg_t                 cfg,
    output logic                                     done,
    output logic signed [prrs_pkg::CoordW-1:0]       dev_x0,
    output logic signed [prrs_pkg::CoordW-1:0]       dev_y0,
    output logic signed [prrs_pkg::CoordW-1:0]       dev_x1,
    output logic signed [prrs_pkg::CoordW-1:0]       dev_y1,
    output logic        [prrs_pkg::StatusW-1:0]      status
);
    import prrs_pkg::*;

    logic signed [AccW-1:0] ox, oy, ex0, ex1, ey0, ey1;
    logic signed [AccW-1:0] dx0_next, dx1_next, dy0_next, dy1_next;
    logic signed [AccW-1:0] dx0_reg, dx1_reg, dy0_reg, dy1_reg;
    logic                   c_vld_reg;

    always_comb
    begin
        ox  = AccW'(cfg.off_x);
        oy  = AccW'(cfg.off_y);
        ex0 = AccW'(qx0);
        ex1 = AccW'(qx1);
        ey0 = AccW'(qy0);
        ey1 = AccW'(qy1);
        unique case (cfg.rot)
            ROT_0:
            begin
                dx0_next = ox + ex0;
                dx1_next = ox + ex1;
                dy0_next = oy + ey0;
                dy1_next = oy + ey1;
            end
            ROT_90:
            begin
                dx0_next = ox + ey0;
                dx1_next = ox + ey1;
                dy0_next = oy - ex1;
                dy1_next = oy - ex0;
            end
            ROT_180:
            begin
                dx0_next = ox - ex1;
                dx1_next = ox - ex0;
                dy0_next = oy - ey1;
                dy1_next = oy - ey0;
            end
            ROT_270:
            begin
                dx0_next = ox - ey1;
                dx1_next = ox - ey0;
                dy0_next = oy + ex0;
                dy1_next = oy + ex1;
            end
            default:
            begin
                dx0_next = '0;
                dx1_next = '0;
                dy0_next = '0;
                dy1_next = '0;
            end
        endcase
    end

    logic                     done_reg;
    logic signed [CoordW-1:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic [StatusW-1:0]       status_reg;
    logic                     ok;
    logic                     swap_x, swap_y;

    assign ok     = cfg.status == ST_OK;
    assign swap_x = dx0_reg > dx1_reg;
    assign swap_y = dy0_reg > dy1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            c_vld_reg <= in_vld;
            done_reg  <= c_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx0_reg    <= dx0_next;
        dx1_reg    <= dx1_next;
        dy0_reg    <= dy0_next;
        dy1_reg    <= dy1_next;
        status_reg <= cfg.status;
        x0_reg     <= ok ? sat_coord(swap_x ? dx1_reg : dx0_reg) : '0;
        x1_reg     <= ok ? sat_coord(swap_x ? dx0_reg : dx1_reg) : '0;
        y0_reg     <= ok ? sat_coord(swap_y ? dy1_reg : dy0_reg) : '0;
        y1_reg     <= ok ? sat_coord(swap_y ? dy0_reg : dy1_reg) : '0;
    end

    assign done   = done_reg;
    assign dev_x0 = x0_reg;
    assign dev_y0 = y0_reg;
    assign dev_x1 = x1_reg;
    assign dev_y1 = y1_reg;
    assign status = status_reg;

endmodule
`default_nettype wire

@@ sv/page_rect_rotate_scale.sv @@
// Top level of the page rectangle rotate/scale pipeline.
// A rectangle beat is taken whenever start is high; busy stays low, so one
// rectangle enters every clock. It leaves as a one-cycle done strobe with
// dev_x0..dev_y1 and status. The depth is set by the 63-step restoring
// divider in each of the four scaling lanes (one quotient bit per stage)
// plus input capture, alignment, multiply, clamp and two output stages.
// The receiver cannot stall: sample the outputs whenever done is high.
// Write the configuration only while no rectangle is in flight.
`default_nettype none
module page_rect_rotate_scale (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic        [prrs_pkg::AddrW-1:0]   paddr,
    input  wire logic        [prrs_pkg::DataW-1:0]   pwdata,
    output logic             [prrs_pkg::DataW-1:0]   prdata,
    output logic                                     pready,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [prrs_pkg::CoordW-1:0]  user_x0,
    input  wire logic signed [prrs_pkg::CoordW-1:0]  user_y0,
    input  wire logic signed [prrs_pkg::CoordW-1:0]  user_x1,
    input  wire logic signed [prrs_pkg::CoordW-1:0]  user_y1,
    output logic                                     done,
    output logic signed      [prrs_pkg::CoordW-1:0]  dev_x0,
    output logic signed      [prrs_pkg::CoordW-1:0]  dev_y0,
    output logic signed      [prrs_pkg::CoordW-1:0]  dev_x1,
    output logic signed      [prrs_pkg::CoordW-1:0]  dev_y1,
    output logic             [prrs_pkg::StatusW-1:0] status
);
    import prrs_pkg::*;

    page_cfg_t cfg;

    prrs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Fully pipelined: never hold off a start beat.
    assign busy = 1'b0;

    // Capture the incoming beat.
    logic                     in_vld_reg;
    logic signed [CoordW-1:0] ux0_reg, uy0_reg, ux1_reg, uy1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        ux0_reg <= user_x0;
        uy0_reg <= user_y0;
        ux1_reg <= user_x1;
        uy1_reg <= user_y1;
    end

    // Four lanes run in lockstep; x lanes scale by cw/mw, y lanes by ch/mh (by 1 at 0 degrees).
    logic                 vx0, vy0, vx1, vy1;
    logic signed [QW-1:0] qx0, qy0, qx1, qy1;

    prrs_lane u_lane_x0 (
        .clk (clk), .rst_n (rst_n), .in_vld (in_vld_reg), .u (ux0_reg),
        .num (cfg.num_x), .den (cfg.den_x), .out_vld (vx0), .q (qx0)
    );
    prrs_lane u_lane_y0 (
        .clk (clk), .rst_n (rst_n), .in_vld (in_vld_reg), .u (uy0_reg),
        .num (cfg.num_y), .den (cfg.den_y), .out_vld (vy0), .q (qy0)
    );
    prrs_lane u_lane_x1 (
        .clk (clk), .rst_n (rst_n), .in_vld (in_vld_reg), .u (ux1_reg),
        .num (cfg.num_x), .den (cfg.den_x), .out_vld (vx1), .q (qx1)
    );
    prrs_lane u_lane_y1 (
        .clk (clk), .rst_n (rst_n), .in_vld (in_vld_reg), .u (uy1_reg),
        .num (cfg.num_y), .den (cfg.den_y), .out_vld (vy1), .q (qy1)
    );

    prrs_post u_post (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_vld (vx0 && vy0 && vx1 && vy1),
        .qx0    (qx0),
        .qy0    (qy0),
        .qx1    (qx1),
        .qy1    (qy1),
        .cfg    (cfg),
        .done   (done),
        .dev_x0 (dev_x0),
        .dev_y0 (dev_y0),
        .dev_x1 (dev_x1),
        .dev_y1 (dev_y1),
        .status (status)
    );

endmodule
`default_nettype wire

@@ sv/prrs_checker.sv @@
// Port-level checks for the page rectangle rotate/scale block.
`default_nettype none
module prrs_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               done,
    input wire logic signed [31:0] dev_x0,
    input wire logic signed [31:0] dev_y0,
    input wire logic signed [31:0] dev_x1,
    input wire logic signed [31:0] dev_y1,
    input wire logic        [1:0]  status
);
    import prrs_pkg::*;

    localparam int Latency = 69;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $past(start && !busy, Latency) |-> done)
        else $error("rectangle beat did not complete at the fixed latency");

    a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (dev_x0 <= dev_x1) && (dev_y0 <= dev_y1))
        else $error("device rectangle not ordered");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |->
            (dev_x0 == 0 && dev_y0 == 0 && dev_x1 == 0 && dev_y1 == 0))
        else $error("error result carries nonzero coordinates");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> status <= ST_ROT)
        else $error("undefined status code");

endmodule

bind page_rect_rotate_scale prrs_checker u_prrs_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .dev_x0 (dev_x0),
    .dev_y0 (dev_y0),
    .dev_x1 (dev_x1),
    .dev_y1 (dev_y1),
    .status (status)
);
`default_nettype wire
